// File: sv/fpat_pkg.sv
// Shared types and constants of the FIFO paged address translator.
package fpat_pkg;

  // Fixed field widths
  localparam int unsigned NUM_PAGES = 8;
  localparam int unsigned PAGE_W    = 3;
  localparam int unsigned OFFSET_W  = 12;
  localparam int unsigned FRAME_W   = 8;
  localparam int unsigned PHYS_W    = FRAME_W + OFFSET_W;

  // Item kinds
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_ACCESS = 1'b1;

  // Input word
  typedef struct packed {
    logic                mode;
    logic [PAGE_W-1:0]   page;
    logic [OFFSET_W-1:0] offset;
    logic                is_write;
    logic [FRAME_W-1:0]  frame;
    logic [FRAME_W-1:0]  disk_frame;
    logic                present;
  } in_word_t;

  // Output word
  typedef struct packed {
    logic [PHYS_W-1:0] phys_address;
    logic              fault;
    logic              victim_valid;
    logic [PAGE_W-1:0] victim_page;
    logic              victim_dirty;
  } out_word_t;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } ctrl_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;  // latch the input word
    logic exec;     // apply the update and load the output register
  } ctrl_cmd_t;

endpackage

// File: sv/fpat_ctrl.sv
// Controller: input capture, execute step and output valid tracking.
module fpat_ctrl
  import fpat_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ctrl_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        fire;

  // State and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.exec    = 1'b0;
    fire          = 1'b0;
    in_stall_o    = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // output register must be free or draining this cycle
        if (!out_valid_q || !out_stall_i) begin
          fire       = 1'b1;
          cmd_o.exec = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // A new result only follows an execute step
  a_rise_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EXEC))
    else $error("output valid rose without an execute step");

  // A captured word is executed next
  a_capture_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> state_q == ST_EXEC)
    else $error("capture did not lead to execute");

  // With a free output register, the execute step does not stall and returns to idle in the next cycle
  a_exec_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && !out_valid_q) |=> state_q == ST_IDLE)
    else $error("execute step stalled with free output");

endmodule

// File: sv/fpat_datapath.sv
// Datapath: page table, resident ring, translation and output register.
module fpat_datapath
  import fpat_pkg::*;
#(
  parameter int unsigned RESIDENT_FRAMES = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ctrl_cmd_t cmd_i,
  input  in_word_t  in_word_i,
  output out_word_t out_word_o
);

  localparam int unsigned SLOT_W = (RESIDENT_FRAMES > 1) ? $clog2(RESIDENT_FRAMES) : 1;

  in_word_t            item_q;
  logic [FRAME_W-1:0]  page_frame_q [NUM_PAGES];
  logic [FRAME_W-1:0]  page_disk_q  [NUM_PAGES];
  logic [NUM_PAGES-1:0] page_present_q, page_present_d;
  logic [NUM_PAGES-1:0] page_dirty_q, page_dirty_d;
  logic [PAGE_W-1:0]   ring_page_q [RESIDENT_FRAMES];
  logic [RESIDENT_FRAMES-1:0] ring_valid_q, ring_valid_d;
  logic [SLOT_W-1:0]   ring_ptr_q, ring_ptr_d;
  out_word_t           out_q, out_d;

  logic [PAGE_W-1:0]   p;
  logic                frame_we;
  logic [FRAME_W-1:0]  frame_wdata;
  logic                disk_we;
  logic                ring_we;
  logic [SLOT_W-1:0]   ring_slot;
  logic                do_insert;
  logic [FRAME_W-1:0]  frame_eff;
  logic [PAGE_W-1:0]   victim;
  logic                lo_found, hi_found;
  logic [SLOT_W-1:0]   lo_idx, hi_idx;

  assign p = item_q.page;

  // First free ring slot at or after the pointer, else the first overall
  always_comb begin
    lo_found = 1'b0;
    hi_found = 1'b0;
    lo_idx   = '0;
    hi_idx   = '0;
    for (int i = 0; i < RESIDENT_FRAMES; i++) begin
      if (!ring_valid_q[i]) begin
        if (!lo_found) begin
          lo_found = 1'b1;
          lo_idx   = SLOT_W'(i);
        end
        if (!hi_found && (i >= int'(ring_ptr_q))) begin
          hi_found = 1'b1;
          hi_idx   = SLOT_W'(i);
        end
      end
    end
  end

  // Item execution: table update, ring insert or removal, translation
  always_comb begin
    page_present_d = page_present_q;
    page_dirty_d   = page_dirty_q;
    ring_valid_d   = ring_valid_q;
    ring_ptr_d     = ring_ptr_q;
    frame_we       = 1'b0;
    frame_wdata    = item_q.frame;
    disk_we        = 1'b0;
    ring_we        = 1'b0;
    ring_slot      = ring_ptr_q;
    do_insert      = 1'b0;
    frame_eff      = page_frame_q[p];
    victim         = ring_page_q[ring_ptr_q];
    out_d          = '0;

    if (item_q.mode == MODE_LOAD) begin
      frame_we        = 1'b1;
      disk_we         = 1'b1;
      page_dirty_d[p] = 1'b0;
      if (item_q.present) begin
        do_insert = !page_present_q[p];
      end else if (page_present_q[p]) begin
        for (int i = 0; i < RESIDENT_FRAMES; i++) begin
          if (ring_valid_q[i] && ring_page_q[i] == p) ring_valid_d[i] = 1'b0;
        end
        page_present_d[p] = 1'b0;
      end
    end else if (!page_present_q[p]) begin
      // miss: bring the page in from its disk frame
      out_d.fault     = 1'b1;
      do_insert       = 1'b1;
      frame_we        = 1'b1;
      frame_wdata     = page_disk_q[p];
      frame_eff       = page_disk_q[p];
      page_dirty_d[p] = 1'b0;
    end

    if (do_insert) begin
      ring_we = 1'b1;
      if (lo_found) begin
        ring_slot = hi_found ? hi_idx : lo_idx;
      end else begin
        // ring full: evict the oldest page
        out_d.victim_valid     = 1'b1;
        out_d.victim_page      = victim;
        out_d.victim_dirty     = page_dirty_q[victim];
        page_present_d[victim] = 1'b0;
        page_dirty_d[victim]   = 1'b0;
        ring_ptr_d = (ring_ptr_q == SLOT_W'(RESIDENT_FRAMES - 1)) ? '0
                                                                  : ring_ptr_q + SLOT_W'(1);
      end
      ring_valid_d[ring_slot] = 1'b1;
      page_present_d[p]       = 1'b1;
    end

    if (item_q.mode == MODE_ACCESS) begin
      out_d.phys_address = {frame_eff, item_q.offset};
      if (item_q.is_write) page_dirty_d[p] = 1'b1;
    end
  end

  // Input word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= in_word_i;
  end

  // Payload stores and output word
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_q <= out_d;
      if (frame_we) page_frame_q[p] <= frame_wdata;
      if (disk_we)  page_disk_q[p]  <= item_q.disk_frame;
      if (ring_we)  ring_page_q[ring_slot] <= p;
    end
  end

  // Control state of table and ring
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_present_q <= '0;
      page_dirty_q   <= '0;
      ring_valid_q   <= '0;
      ring_ptr_q     <= '0;
    end else if (cmd_i.exec) begin
      page_present_q <= page_present_d;
      page_dirty_q   <= page_dirty_d;
      ring_valid_q   <= ring_valid_d;
      ring_ptr_q     <= ring_ptr_d;
    end
  end

  assign out_word_o = out_q;

  // Resident pages and occupied ring slots stay in step
  a_ring_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(page_present_q) == $countones(ring_valid_q))
    else $error("resident page count differs from ring occupancy");

  // An accessed page is resident afterwards
  a_access_resident: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && item_q.mode == MODE_ACCESS) |=> page_present_q[$past(item_q.page)])
    else $error("accessed page not resident after execution");

  // A page never evicts itself
  a_victim_other: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |=> !(out_q.victim_valid && out_q.victim_page == $past(item_q.page)))
    else $error("victim equals the incoming page");

endmodule

// File: sv/fifo_paged_address_translator.sv
// A word accepted into the input register is executed in the execute state, which loads
// the output register and raises output valid for its result word.
// Capture then execute: no new word is accepted until the previous one has executed;
// execute waits while a previous result is held by a stalled output register.
// Reset: asynchronous active low; clears present, dirty and ring valid bits and the
// ring pointer. Frame tables and ring entries hold whatever was last written.
module fifo_paged_address_translator
  import fpat_pkg::*;
#(
  parameter int unsigned RESIDENT_FRAMES = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  ctrl_cmd_t cmd;

  // Sequencing
  fpat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Tables, ring and translation
  fpat_datapath #(
    .RESIDENT_FRAMES (RESIDENT_FRAMES)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_word_i  (in_word_i),
    .out_word_o (out_word_o)
  );

endmodule
